// ===== hdl/i64dlw_pkg.sv =====
// Shared constants, types and the double-dabble step for the decimal line writer.
package i64dlw_pkg;

	localparam int MAX_DIGITS    = 20;
	localparam int VALUE_W       = 64;
	localparam int BCD_W         = 4 * MAX_DIGITS;
	localparam int DIG_IDX_W     = $clog2(MAX_DIGITS);
	localparam int LEN_W         = 5;
	localparam int SPACE_W       = 16;
	localparam int BITS_PER_STEP = 4;
	localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
	localparam int STEP_W        = $clog2(CONV_STEPS);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	typedef logic [MAX_DIGITS-1:0][3:0] bcd_t;

	typedef logic [2:0] byte_sel_t;
	localparam byte_sel_t SEL_NONE  = 3'd0;
	localparam byte_sel_t SEL_MARK  = 3'd1;
	localparam byte_sel_t SEL_MINUS = 3'd2;
	localparam byte_sel_t SEL_DIGIT = 3'd3;
	localparam byte_sel_t SEL_CR    = 3'd4;
	localparam byte_sel_t SEL_LF    = 3'd5;

	typedef struct packed {
		logic      load;
		logic      conv;
		logic      measure;
		logic      dig_dec;
		byte_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic fits;
		logic neg;
		logic dig_last;
	} dp_stat_t;

	// one shift-add-3 step: fix up every digit, then shift in the next binary bit
	function automatic bcd_t dd_shift(input bcd_t bcd, input logic b);
		bcd_t             adj;
		logic [BCD_W-1:0] flat;
		adj = bcd;
		for (int k = 0; k < MAX_DIGITS; k++) begin
			if (bcd[k] >= 4'd5) begin
				adj[k] = bcd[k] + 4'd3;
			end
		end
		flat = adj;
		dd_shift = {flat[BCD_W-2:0], b};
	endfunction

endpackage

// ===== hdl/i64dlw_if.sv =====
// Valid/ready channel interfaces for input items and output bytes.
interface i64dlw_item_if;
	logic               valid;
	logic               ready;
	logic [7:0]         type_marker;
	logic signed [63:0] value;
	logic [15:0]        space_left;

	modport source(output valid, type_marker, value, space_left, input ready);
	modport sink(input valid, type_marker, value, space_left, output ready);
endinterface

interface i64dlw_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	logic       overflow;

	modport source(output valid, out_byte, last_byte, overflow, input ready);
	modport sink(input valid, out_byte, last_byte, overflow, output ready);
endinterface

// ===== hdl/i64dlw_dp.sv =====
// Datapath: magnitude, BCD conversion register, digit count, fit check and byte select.
module i64dlw_dp import i64dlw_pkg::*; (
	input  logic               clk,
	input  logic [7:0]         type_marker,
	input  logic signed [63:0] value,
	input  logic [15:0]        space_left,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic [7:0]         out_byte
);

	logic [7:0]           marker_q;
	logic [SPACE_W-1:0]   space_q;
	logic                 neg_q;
	logic [VALUE_W-1:0]   mag_q;
	bcd_t                 bcd_q;
	logic [DIG_IDX_W-1:0] dig_q;

	logic [VALUE_W-1:0]   raw;
	logic [VALUE_W-1:0]   mag_c;
	bcd_t                 bcd_nx;
	logic [VALUE_W-1:0]   mag_nx;
	logic [LEN_W-1:0]     ndig_c;
	logic [LEN_W-1:0]     len_c;

	assign raw   = value;
	// two's complement negate; -2^63 comes out as magnitude 2^63
	assign mag_c = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

	always_comb begin
		bcd_nx = bcd_q;
		mag_nx = mag_q;
		for (int j = 0; j < BITS_PER_STEP; j++) begin
			bcd_nx = dd_shift(bcd_nx, mag_nx[VALUE_W-1]);
			mag_nx = {mag_nx[VALUE_W-2:0], 1'b0};
		end
	end

	// digit count: position of the top nonzero digit, at least one
	always_comb begin
		ndig_c = LEN_W'(1);
		for (int k = 1; k < MAX_DIGITS; k++) begin
			if (bcd_q[k] != 4'd0) begin
				ndig_c = LEN_W'(k + 1);
			end
		end
	end

	assign len_c         = LEN_W'(3) + LEN_W'(neg_q) + ndig_c;
	assign stat.fits     = SPACE_W'(len_c) < space_q;
	assign stat.neg      = neg_q;
	assign stat.dig_last = (dig_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			marker_q <= type_marker;
			space_q  <= space_left;
			neg_q    <= raw[VALUE_W-1];
			mag_q    <= mag_c;
			bcd_q    <= '0;
		end else if (cmd.conv) begin
			mag_q <= mag_nx;
			bcd_q <= bcd_nx;
		end
		if (cmd.measure) begin
			dig_q <= DIG_IDX_W'(ndig_c - LEN_W'(1));
		end else if (cmd.dig_dec) begin
			dig_q <= dig_q - DIG_IDX_W'(1);
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_MARK:  out_byte = marker_q;
			SEL_MINUS: out_byte = CHAR_MINUS;
			SEL_DIGIT: out_byte = CHAR_ZERO + {4'b0000, bcd_q[dig_q]};
			SEL_CR:    out_byte = CHAR_CR;
			SEL_LF:    out_byte = CHAR_LF;
			default:   out_byte = 8'h00;
		endcase
	end

endmodule

// ===== hdl/i64dlw_ctrl.sv =====
// Controller: sequences load, conversion steps, measurement and byte emission.
module i64dlw_ctrl import i64dlw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output logic     out_last,
	output logic     out_ovf,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_CONV    = 4'd1;
	localparam logic [3:0] ST_MEASURE = 4'd2;
	localparam logic [3:0] ST_MARK    = 4'd3;
	localparam logic [3:0] ST_SIGN    = 4'd4;
	localparam logic [3:0] ST_DIGIT   = 4'd5;
	localparam logic [3:0] ST_CR      = 4'd6;
	localparam logic [3:0] ST_LF      = 4'd7;
	localparam logic [3:0] ST_OVF     = 4'd8;

	logic [3:0]        state_q;
	logic [3:0]        state_nx;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		state_nx    = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		out_last    = 1'b0;
		out_ovf     = 1'b0;
		cmd.load    = 1'b0;
		cmd.conv    = 1'b0;
		cmd.measure = 1'b0;
		cmd.dig_dec = 1'b0;
		cmd.sel     = SEL_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				if (step_q == STEP_W'(CONV_STEPS - 1)) begin
					state_nx = ST_MEASURE;
				end
			end
			ST_MEASURE: begin
				cmd.measure = 1'b1;
				state_nx    = stat.fits ? ST_MARK : ST_OVF;
			end
			ST_MARK: begin
				out_valid = 1'b1;
				cmd.sel   = SEL_MARK;
				if (out_ready) begin
					state_nx = stat.neg ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				out_valid = 1'b1;
				cmd.sel   = SEL_MINUS;
				if (out_ready) begin
					state_nx = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				out_valid = 1'b1;
				cmd.sel   = SEL_DIGIT;
				if (out_ready) begin
					if (stat.dig_last) begin
						state_nx = ST_CR;
					end else begin
						cmd.dig_dec = 1'b1;
					end
				end
			end
			ST_CR: begin
				out_valid = 1'b1;
				cmd.sel   = SEL_CR;
				if (out_ready) begin
					state_nx = ST_LF;
				end
			end
			ST_LF: begin
				out_valid = 1'b1;
				out_last  = 1'b1;
				cmd.sel   = SEL_LF;
				if (out_ready) begin
					state_nx = ST_IDLE;
				end
			end
			ST_OVF: begin
				out_valid = 1'b1;
				out_last  = 1'b1;
				out_ovf   = 1'b1;
				if (out_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.conv) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

endmodule

// ===== hdl/int64_decimal_line_writer_core.sv =====
// Item accepted in idle; conversion steps (4 bits each) and a measure state follow.
// The first byte is offered after the measure state, then one byte per cycle
// while the sink is ready: marker, sign if negative, 1..19 digits, CR, LF (or one overflow result).
// A line is L = 4..23 bytes (1 on overflow); the next item is taken only after its last byte.
// arst_n clears the controller to idle; datapath registers load with each item.
module int64_decimal_line_writer_core import i64dlw_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	i64dlw_item_if.sink   item,
	i64dlw_text_if.source text
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	i64dlw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (text.valid),
		.out_ready (text.ready),
		.out_last  (text.last_byte),
		.out_ovf   (text.overflow),
		.stat      (stat),
		.cmd       (cmd)
	);

	i64dlw_dp u_dp (
		.clk         (clk),
		.type_marker (item.type_marker),
		.value       (item.value),
		.space_left  (item.space_left),
		.cmd         (cmd),
		.stat        (stat),
		.out_byte    (text.out_byte)
	);

endmodule

// ===== hdl/i64dlw_chk.sv =====
// Port-level checker for the decimal line writer, bound to the top level.
module i64dlw_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic [7:0] item_marker,
	input logic       text_valid,
	input logic       text_ready,
	input logic [7:0] out_byte,
	input logic       last_byte,
	input logic       overflow
);

	logic       item_xfer;
	logic       text_xfer;
	logic       busy_q;
	logic       first_q;
	logic [4:0] cnt_q;
	logic [7:0] marker_q;

	assign item_xfer = item_valid && item_ready;
	assign text_xfer = text_valid && text_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else if (item_xfer) begin
			busy_q  <= 1'b1;
			first_q <= 1'b1;
			cnt_q   <= '0;
		end else if (text_xfer) begin
			first_q <= 1'b0;
			cnt_q   <= cnt_q + 5'd1;
			if (last_byte) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			marker_q <= item_marker;
		end
	end

	// a new item only after the previous line is fully transferred
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |-> !busy_q) else $error("item accepted while a line is pending");

	a_out_owned: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> busy_q) else $error("output offered with no item in flight");

	a_ovf_form: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && overflow |-> last_byte && out_byte == 8'h00)
		else $error("overflow result malformed");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		text_xfer |-> cnt_q < 5'd23) else $error("line longer than 23 bytes");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		text_xfer && first_q && !overflow |-> out_byte == marker_q)
		else $error("first byte of line is not the type marker");

endmodule

bind int64_decimal_line_writer_core i64dlw_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_marker (item.type_marker),
	.text_valid  (text.valid),
	.text_ready  (text.ready),
	.out_byte    (text.out_byte),
	.last_byte   (text.last_byte),
	.overflow    (text.overflow)
);

// ===== dv/int64_decimal_line_writer_core_test.sv =====
// Self-checking testbench for the signed 64-bit decimal line writer core.
module int64_decimal_line_writer_core_test import i64dlw_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 308;
	localparam int DRAIN_CYCLES = 40;
	localparam int PRINT_CAP    = 50;
	localparam int NROWS        = 22;

	localparam logic signed [63:0] INT_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] INT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ROW_MODEL,
		ROW_TEXT,
		ROW_OVF
	} row_kind_t;

	typedef struct {
		logic [7:0]         marker;
		logic signed [63:0] value;
		logic [15:0]        space;
	} line_req_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic       ovf;
	} text_beat_t;

	typedef struct {
		logic [7:0]         marker;
		logic signed [63:0] value;
		logic [15:0]        space;
		row_kind_t          kind;
		string              body;
	} plan_row_t;

	// body holds marker, sign and digits; CR LF are appended
	plan_row_t plan [0:NROWS-1] = '{
		'{8'h3A, 64'sd0, 16'd5, ROW_TEXT, ":0"},
		'{8'h3A, 64'sd0, 16'd4, ROW_OVF, ""},
		'{8'h3A, INT_MIN, 16'hFFFF, ROW_TEXT, ":-9223372036854775808"},
		'{8'h3A, INT_MIN, 16'd23, ROW_OVF, ""},
		'{8'h3A, INT_MIN, 16'd24, ROW_MODEL, ""},
		'{8'h3A, INT_MAX, 16'hFFFF, ROW_TEXT, ":9223372036854775807"},
		'{8'h3A, INT_MAX, 16'd22, ROW_OVF, ""},
		'{8'h3A, -64'sd1, 16'd6, ROW_TEXT, ":-1"},
		'{8'h3A, -64'sd1, 16'd5, ROW_OVF, ""},
		'{8'h3A, 64'sd5, 16'd0, ROW_OVF, ""},
		'{8'h3A, 64'sd7, 16'd1, ROW_OVF, ""},
		'{8'hFF, 64'sd9, 16'd100, ROW_MODEL, ""},
		'{8'h00, 64'sd10, 16'd100, ROW_MODEL, ""},
		'{8'h55, 64'sd99, 16'd32768, ROW_MODEL, ""},
		'{8'hAA, 64'sd100, 16'd7, ROW_MODEL, ""},
		'{8'h2B, -64'sd999999999999999999, 16'd40, ROW_MODEL, ""},
		'{8'h2B, 64'sd1000000000000000000, 16'd40, ROW_MODEL, ""},
		'{8'h3A, 64'sh8000_0000_0000_0001, 16'd30, ROW_MODEL, ""},
		'{8'h3A, 64'sh5555_5555_5555_5555, 16'h5555, ROW_MODEL, ""},
		'{8'h3A, 64'shAAAA_AAAA_AAAA_AAAA, 16'hAAAA, ROW_MODEL, ""},
		'{8'h3A, -64'sd10, 16'h7FFF, ROW_MODEL, ""},
		'{8'h24, 64'sd1, 16'h8000, ROW_MODEL, ""}
	};

	logic clk;
	logic arst_n;
	bit   calm;
	int   mismatches;
	int   quiet_cycles;

	text_beat_t expected_text[$];

	i64dlw_item_if item_ch();
	i64dlw_text_if text_ch();

	int64_decimal_line_writer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.text   (text_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("ERROR %0t: %s", $realtime, what);
		end
	endtask

	function automatic logic [63:0] magnitude_of(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic int digit_count(input logic [63:0] m);
		int n;
		n = 1;
		while (m >= 64'd10) begin
			m = m / 64'd10;
			n++;
		end
		return n;
	endfunction

	function automatic int line_length(input logic signed [63:0] v);
		return 3 + int'(v[63]) + digit_count(magnitude_of(v));
	endfunction

	function automatic void predict_line(input line_req_t req);
		logic [63:0] mag;
		logic [3:0]  dec [MAX_DIGITS];
		int          nd;
		mag = magnitude_of(req.value);
		nd  = digit_count(mag);
		if (line_length(req.value) >= int'(req.space)) begin
			expected_text.push_back('{8'h00, 1'b1, 1'b1});
		end else begin
			for (int i = nd - 1; i >= 0; i--) begin
				dec[i] = 4'(mag % 64'd10);
				mag    = mag / 64'd10;
			end
			expected_text.push_back('{req.marker, 1'b0, 1'b0});
			if (req.value[63]) begin
				expected_text.push_back('{CHAR_MINUS, 1'b0, 1'b0});
			end
			for (int i = 0; i < nd; i++) begin
				expected_text.push_back('{CHAR_ZERO + 8'(dec[i]), 1'b0, 1'b0});
			end
			expected_text.push_back('{CHAR_CR, 1'b0, 1'b0});
			expected_text.push_back('{CHAR_LF, 1'b1, 1'b0});
		end
	endfunction

	function automatic void queue_golden(input row_kind_t kind, input string body);
		if (kind == ROW_OVF) begin
			expected_text.push_back('{8'h00, 1'b1, 1'b1});
		end else begin
			for (int i = 0; i < body.len(); i++) begin
				expected_text.push_back('{body[i], 1'b0, 1'b0});
			end
			expected_text.push_back('{CHAR_CR, 1'b0, 1'b0});
			expected_text.push_back('{CHAR_LF, 1'b1, 1'b0});
		end
	endfunction

	function automatic line_req_t random_line();
		line_req_t   req;
		logic [63:0] raw;
		logic [63:0] p;
		int          nb;
		int          ln;
		raw        = {$urandom(), $urandom()};
		req.marker = 8'($urandom());
		case ($urandom_range(0, 9))
			0, 1: begin
				req.value = raw;
			end
			2, 3, 4, 5: begin
				nb        = $urandom_range(0, 63);
				req.value = raw & ((64'd1 << nb) - 64'd1);
				if ($urandom_range(0, 1) == 1) begin
					req.value = -req.value;
				end
			end
			6, 7: begin
				// around a power of ten, where the digit count steps
				p = 64'd1;
				repeat ($urandom_range(0, 19)) p = p * 64'd10;
				req.value = p + 64'($urandom_range(0, 2)) - 64'd1;
				if ($urandom_range(0, 1) == 1) begin
					req.value = -req.value;
				end
			end
			default: begin
				case ($urandom_range(0, 4))
					0:       req.value = INT_MIN;
					1:       req.value = INT_MAX;
					2:       req.value = 64'sd0;
					3:       req.value = -64'sd1;
					default: req.value = 64'sd1;
				endcase
			end
		endcase
		ln = line_length(req.value);
		case ($urandom_range(0, 9))
			0:       req.space = 16'($urandom());
			1:       req.space = 16'(ln);
			2:       req.space = 16'(ln + 1);
			3:       req.space = 16'($urandom_range(0, ln));
			default: req.space = 16'(ln + 1 + $urandom_range(0, 60));
		endcase
		return req;
	endfunction

	// drives one item, holds it until the transfer, then records what it should produce
	task automatic offer_line(input line_req_t req, input row_kind_t kind, input string body);
		while (!calm && $urandom_range(0, 99) < 9) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.type_marker <= req.marker;
		item_ch.value       <= req.value;
		item_ch.space_left  <= req.space;
		do begin
			@(posedge clk);
		end while (!item_ch.ready);
		if (kind == ROW_MODEL) begin
			predict_line(req);
		end else begin
			queue_golden(kind, body);
		end
	endtask

	initial begin
		text_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			text_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
		end
	end

	always @(posedge clk) begin
		text_beat_t want;
		if (arst_n && text_ch.valid && text_ch.ready) begin
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", text_ch.out_byte));
			end else begin
				want = expected_text.pop_front();
				if (text_ch.out_byte !== want.ch) begin
					report_mismatch($sformatf("out_byte %02h, want %02h",
						text_ch.out_byte, want.ch));
				end
				if (text_ch.last_byte !== want.last) begin
					report_mismatch($sformatf("last_byte %b, want %b",
						text_ch.last_byte, want.last));
				end
				if (text_ch.overflow !== want.ovf) begin
					report_mismatch($sformatf("overflow %b, want %b",
						text_ch.overflow, want.ovf));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (text_ch.valid && text_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		line_req_t req;
		mismatches          = 0;
		quiet_cycles        = 0;
		calm                = 1'b0;
		arst_n             <= 1'b0;
		item_ch.valid      <= 1'b0;
		item_ch.type_marker <= 8'h00;
		item_ch.value      <= 64'sd0;
		item_ch.space_left <= 16'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NROWS; r++) begin
			req.marker = plan[r].marker;
			req.value  = plan[r].value;
			req.space  = plan[r].space;
			offer_line(req, plan[r].kind, plan[r].body);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// one long run with both sides at full rate
			calm <= (n >= 120 && n < 200);
			offer_line(random_line(), ROW_MODEL, "");
		end
		item_ch.valid <= 1'b0;
		calm          <= 1'b0;

		while (expected_text.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
